// ===== rtl/audio_sample_ring_buffer_unit_defines.svh =====
// Assertion macros for the audio sample ring buffer.
// Taken in by the top level; no other dependencies.
`ifndef AUDIO_SAMPLE_RING_BUFFER_UNIT_DEFINES_SVH
`define AUDIO_SAMPLE_RING_BUFFER_UNIT_DEFINES_SVH

// same-cycle implication
`define ASRB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASRB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/asrb_pkg.sv =====
// Shared types and constants for the audio sample ring buffer.
// No dependencies.
package asrb_pkg;

    localparam int CAPACITY_DEF    = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int OPCODE_BITS  = 3;
    localparam int SAMPLE_W     = 16;
    localparam int AMOUNT_BITS  = 11;
    localparam int FILL_BITS    = 11;
    localparam int OVERRUN_BITS = 16;
    localparam int IN_DATA_BITS  = 32;
    localparam int OUT_DATA_BITS = 48;

    localparam logic [OVERRUN_BITS-1:0] OVERRUN_MAX = '1;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_PUSH    = 3'd0,
        OP_READ    = 3'd1,
        OP_PEEK    = 3'd2,
        OP_ADVANCE = 3'd3,
        OP_CLEAR   = 3'd4
    } op_t;

    typedef struct packed {
        logic                    rd;
        logic                    ok;
        logic [FILL_BITS-1:0]    fill;
        logic [OVERRUN_BITS-1:0] overrun;
    } meta_t;

    typedef struct packed {
        logic s1_valid;
        logic out_valid;
    } out_status_t;

endpackage

// ===== rtl/asrb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module asrb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/asrb_ctrl.sv =====
// Cursor, count and overrun state; decodes one accepted word per cycle into its RAM access, if any.
// Depends on asrb_pkg.
module asrb_ctrl #(
    parameter int CAPACITY    = asrb_pkg::CAPACITY_DEF,
    parameter int SAMPLE_BITS = asrb_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic [asrb_pkg::OPCODE_BITS-1:0]    opcode,
    input  logic signed [asrb_pkg::SAMPLE_W-1:0] sample_in,
    input  logic [asrb_pkg::AMOUNT_BITS-1:0]    amount,
    input  logic                                batch_last,
    output logic                                mem_we,
    output logic [$clog2(CAPACITY)-1:0]         mem_waddr,
    output logic [SAMPLE_BITS-1:0]              mem_wdata,
    output logic                                mem_re,
    output logic [$clog2(CAPACITY)-1:0]         mem_raddr,
    output asrb_pkg::meta_t                     meta,
    output logic [$clog2(CAPACITY+1)-1:0]       fill_level
);

    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = ((CW > asrb_pkg::AMOUNT_BITS) ? CW : asrb_pkg::AMOUNT_BITS) + 1;
    localparam logic [AW-1:0] CAP_W   = AW'(CAPACITY);
    localparam logic [PW-1:0] PTR_MAX = PW'(CAPACITY - 1);
    localparam logic [CW-1:0] CAP_C   = CW'(CAPACITY);

    logic [PW-1:0] write_pos_reg, write_pos_next;
    logic [PW-1:0] read_pos_reg, read_pos_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] written_reg, written_next;
    logic [asrb_pkg::OVERRUN_BITS-1:0] overrun_reg, overrun_next;
    logic batch_ovf_reg, batch_ovf_next;

    asrb_pkg::op_t op;
    logic [AW-1:0] amount_w;
    logic [AW-1:0] fill_w;
    logic [AW-1:0] written_w;
    logic [AW-1:0] rd_sum;
    logic [AW-1:0] pk_diff;
    logic [AW-1:0] adv_n;
    logic [AW-1:0] adv_sum;
    logic [AW-1:0] fill_out_w;
    logic [PW-1:0] wp_inc;
    logic [PW-1:0] rd_addr;
    logic [PW-1:0] pk_addr;
    logic [PW-1:0] adv_pos;
    logic signed [31:0] sample_x;
    logic full;
    logic ok;
    logic rd;

    assign op        = asrb_pkg::op_t'(opcode);
    assign amount_w  = AW'(amount);
    assign fill_w    = AW'(fill_reg);
    assign written_w = AW'(written_reg);
    assign sample_x  = 32'(sample_in);
    assign full      = (fill_reg == CAP_C);
    assign wp_inc    = (write_pos_reg == PTR_MAX) ? '0 : write_pos_reg + 1'b1;

    always_comb
    begin
        logic [AW-1:0] pk_fix;
        logic [AW-1:0] adv_fix;
        rd_sum  = AW'(read_pos_reg) + amount_w;
        rd_addr = (rd_sum >= CAP_W) ? PW'(rd_sum - CAP_W) : PW'(rd_sum);
        pk_diff = AW'(write_pos_reg) - amount_w;
        pk_fix  = pk_diff + CAP_W;
        pk_addr = pk_diff[AW-1] ? PW'(pk_fix) : PW'(pk_diff);
        adv_n   = (amount_w > fill_w) ? fill_w : amount_w;
        adv_sum = AW'(read_pos_reg) + adv_n;
        adv_fix = adv_sum - CAP_W;
        adv_pos = (adv_sum >= CAP_W) ? PW'(adv_fix) : PW'(adv_sum);
    end

    always_comb
    begin
        write_pos_next = write_pos_reg;
        read_pos_next  = read_pos_reg;
        fill_next      = fill_reg;
        written_next   = written_reg;
        overrun_next   = overrun_reg;
        batch_ovf_next = batch_ovf_reg;
        ok        = 1'b0;
        rd        = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_raddr = rd_addr;
        unique case (op)
            asrb_pkg::OP_PUSH:
            begin
                mem_we         = accept;
                write_pos_next = wp_inc;
                if (written_reg != CAP_C)
                begin
                    written_next = written_reg + 1'b1;
                end
                if (full)
                begin
                    batch_ovf_next = 1'b1;
                    read_pos_next  = wp_inc;
                end
                else
                begin
                    fill_next = fill_reg + 1'b1;
                end
                ok = !batch_ovf_next;
                if (batch_last)
                begin
                    if (batch_ovf_next && (overrun_reg != asrb_pkg::OVERRUN_MAX))
                    begin
                        overrun_next = overrun_reg + 1'b1;
                    end
                    batch_ovf_next = 1'b0;
                end
            end
            asrb_pkg::OP_READ:
            begin
                ok        = (amount_w < fill_w);
                rd        = ok;
                mem_re    = accept && ok;
                mem_raddr = rd_addr;
            end
            asrb_pkg::OP_PEEK:
            begin
                ok        = (amount_w != '0) && (amount_w <= written_w);
                rd        = ok;
                mem_re    = accept && ok;
                mem_raddr = pk_addr;
            end
            asrb_pkg::OP_ADVANCE:
            begin
                read_pos_next = adv_pos;
                fill_next     = CW'(fill_w - adv_n);
                ok            = 1'b1;
            end
            asrb_pkg::OP_CLEAR:
            begin
                write_pos_next = '0;
                read_pos_next  = '0;
                fill_next      = '0;
                written_next   = '0;
                overrun_next   = '0;
                batch_ovf_next = 1'b0;
                ok             = 1'b1;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    assign mem_waddr  = write_pos_reg;
    assign mem_wdata  = sample_x[SAMPLE_BITS-1:0];
    assign fill_out_w = AW'(fill_next);
    assign fill_level = fill_reg;

    always_comb
    begin
        meta.rd      = rd;
        meta.ok      = ok;
        meta.fill    = fill_out_w[asrb_pkg::FILL_BITS-1:0];
        meta.overrun = overrun_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_pos_reg <= '0;
            read_pos_reg  <= '0;
            fill_reg      <= '0;
            written_reg   <= '0;
            overrun_reg   <= '0;
            batch_ovf_reg <= 1'b0;
        end
        else if (accept)
        begin
            write_pos_reg <= write_pos_next;
            read_pos_reg  <= read_pos_next;
            fill_reg      <= fill_next;
            written_reg   <= written_next;
            overrun_reg   <= overrun_next;
            batch_ovf_reg <= batch_ovf_next;
        end
    end

endmodule

// ===== rtl/asrb_out.sv =====
// Access stage and output register: merges RAM read data with the result fields.
// Depends on asrb_pkg.
module asrb_out #(
    parameter int SAMPLE_BITS = asrb_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  asrb_pkg::meta_t                      meta,
    input  logic [SAMPLE_BITS-1:0]               rdata,
    input  logic                                 m_tready,
    output logic                                 m_tvalid,
    output logic [asrb_pkg::OUT_DATA_BITS-1:0]   m_tdata,
    output logic                                 in_ready,
    output asrb_pkg::out_status_t                status
);

    localparam int PAD = asrb_pkg::OUT_DATA_BITS - asrb_pkg::SAMPLE_W - 1
                         - asrb_pkg::FILL_BITS - asrb_pkg::OVERRUN_BITS;

    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    asrb_pkg::meta_t s1_meta_reg;
    logic [asrb_pkg::OUT_DATA_BITS-1:0] out_data_reg, out_data_next;

    logic s1_move;
    logic signed [SAMPLE_BITS-1:0] rs;
    logic signed [31:0] rx;
    logic [asrb_pkg::SAMPLE_W-1:0] sample_out;

    assign s1_move  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign in_ready = !s1_valid_reg || !out_valid_reg || m_tready;

    assign rs = signed'(rdata);
    assign rx = 32'(rs);
    assign sample_out = s1_meta_reg.rd ? rx[asrb_pkg::SAMPLE_W-1:0] : '0;

    always_comb
    begin
        s1_valid_next  = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_move ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
        out_data_next  = {PAD'(0), s1_meta_reg.overrun, s1_meta_reg.fill,
                          s1_meta_reg.ok, sample_out};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_meta_reg <= meta;
        end
        if (s1_move)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign status.s1_valid  = s1_valid_reg;
    assign status.out_valid = out_valid_reg;

endmodule

// ===== rtl/audio_sample_ring_buffer_unit.sv =====
// Audio sample ring buffer, overwriting the oldest sample when full.
// Path: RAM read register with stage-one result fields, then the output register.
// Throughput: one word per cycle unless m_tready back-pressure stalls the output.
// Reset: cursors, counts and overrun counter clear at once; RAM contents undefined.
// Depends on asrb_pkg, asrb_ram, asrb_ctrl, asrb_out and the defines header.
`include "audio_sample_ring_buffer_unit_defines.svh"

module audio_sample_ring_buffer_unit #(
    parameter int CAPACITY    = asrb_pkg::CAPACITY_DEF,
    parameter int SAMPLE_BITS = asrb_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // opcode [2:0], sample_in [18:3], amount [29:19], zero [31:30]
    input  logic [asrb_pkg::IN_DATA_BITS-1:0]   s_tdata,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // sample_out [15:0], ok [16], fill_level [27:17], overrun_total [43:28], zero [47:44]
    output logic [asrb_pkg::OUT_DATA_BITS-1:0]  m_tdata
);

    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic accept;
    logic mem_we;
    logic mem_re;
    logic [PW-1:0] mem_waddr;
    logic [PW-1:0] mem_raddr;
    logic [SAMPLE_BITS-1:0] mem_wdata;
    logic [SAMPLE_BITS-1:0] mem_rdata;
    logic [CW-1:0] fill_level;
    asrb_pkg::meta_t meta;
    asrb_pkg::out_status_t status;

    assign accept = s_tvalid && s_tready;

    asrb_ctrl #(
        .CAPACITY    (CAPACITY),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .opcode     (s_tdata[2:0]),
        .sample_in  (signed'(s_tdata[18:3])),
        .amount     (s_tdata[29:19]),
        .batch_last (s_tlast),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .meta       (meta),
        .fill_level (fill_level)
    );

    asrb_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    asrb_out #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .meta     (meta),
        .rdata    (mem_rdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .in_ready (s_tready),
        .status   (status)
    );

    `ASRB_ASSERT_NEXT(a_accept_fills_stage, accept, status.s1_valid, "accepted word lost")
    `ASRB_ASSERT_NOW(a_fill_bound, 1'b1, fill_level <= CW'(CAPACITY), "fill above capacity")
    `ASRB_ASSERT_NOW(a_stall_only_full, !s_tready, status.s1_valid && m_tvalid && !m_tready, "needless stall")

endmodule
